@@ design/vcpb_pkg.sv @@
// ----------------------------------------------------------------------------
// vcpb_pkg
// Shared types and constants for the virtual channel packet buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package vcpb_pkg;

	// default sizes of the buffer
	localparam int VC_COUNT_DEF    = 4;
	localparam int VC_DEPTH_DEF    = 16;
	localparam int HANDLE_BITS_DEF = 16;

	// fixed field widths
	localparam int VC_FIELD_W  = 2;
	localparam int CAP_W       = 5;
	localparam int OCC_FIELD_W = 7;

	// capacity register value after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// item action codes
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} vcpb_state_t;

endpackage : vcpb_pkg

`default_nettype wire

@@ design/vcpb_ram.sv @@
// ----------------------------------------------------------------------------
// vcpb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vcpb_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule : vcpb_ram

`default_nettype wire

@@ design/vc_packet_buffer_rr_arbiter_top.sv @@
// ----------------------------------------------------------------------------
// vc_packet_buffer_rr_arbiter_top
// Ejection-side flit buffer with per-VC FIFOs and round-robin packet pop.
// ----------------------------------------------------------------------------
// Every item gives exactly one result. Flits of all VCs share one RAM of
// VC_COUNT*VC_DEPTH entries (handle plus tail mark), each VC a circular
// region of it; head pointers, flit and packet counts sit in flip-flops.
// A push goes through accept, RAM write and result. A pop goes through
// accept, a scan of the VCs one per cycle from the round-robin turn, a
// drain of the packet one flit per cycle through the RAM read port (no
// drain when no packet is found), and result. A new item is taken as
// soon as the previous result has moved to the output register, even if
// that result is still waiting on out_ready. The capacity is clipped to
// VC_DEPTH at push admission; no RAM clearing is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module vc_packet_buffer_rr_arbiter_top
	import vcpb_pkg::*;
#(
	parameter int VC_COUNT    = VC_COUNT_DEF,
	parameter int VC_DEPTH    = VC_DEPTH_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration
	input  wire logic                   cfg_we,
	input  wire logic [CAP_W-1:0]       cfg_wdata,
	// input items
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   action,
	input  wire logic [VC_FIELD_W-1:0]  vc_index,
	input  wire logic [HANDLE_BITS-1:0] flit_handle,
	input  wire logic                   is_tail,
	// result items
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        push_accepted,
	output logic                        packet_valid,
	output logic [HANDLE_BITS-1:0]      packet_handle,
	output logic [VC_FIELD_W-1:0]       packet_vc,
	output logic [OCC_FIELD_W-1:0]      total_occupancy
);

	localparam int VC_W   = (VC_COUNT > 1) ? $clog2(VC_COUNT) : 1;
	localparam int PTR_W  = $clog2(VC_DEPTH);
	localparam int CNT_W  = $clog2(VC_DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int SLOTS  = VC_COUNT * VC_DEPTH;
	localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int OCC_W  = $clog2(SLOTS + 1);
	localparam int WORD_W = HANDLE_BITS + 1;

	localparam logic [VC_W-1:0]   VC_LAST    = VC_W'(VC_COUNT - 1);
	localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(VC_DEPTH - 1);
	localparam logic [SUM_W-1:0]  DEPTH_S    = SUM_W'(VC_DEPTH);
	localparam logic [CNT_W-1:0]  DEPTH_C    = CNT_W'(VC_DEPTH);
	localparam logic [CNT_W-1:0]  CNT_ONE    = CNT_W'(1);
	localparam logic [ADDR_W-1:0] DEPTH_A    = ADDR_W'(VC_DEPTH);
	localparam logic [OCC_W-1:0]  OCC_ONE    = OCC_W'(1);

	vcpb_state_t state_q, state_nx;

	// per-VC bookkeeping
	logic [PTR_W-1:0] head_q     [VC_COUNT];
	logic [CNT_W-1:0] flit_cnt_q [VC_COUNT];
	logic [CNT_W-1:0] pkt_cnt_q  [VC_COUNT];
	logic [VC_W-1:0]  rr_turn_q;
	logic [OCC_W-1:0] total_q;
	logic [CAP_W-1:0] cap_q;

	// current item
	logic                   vc_ok_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic                   tail_q;
	logic [VC_W-1:0]        cur_vc_q;
	logic [VC_W-1:0]        scan_cnt_q;

	// pending result
	logic                   res_acc_q;
	logic                   res_pv_q;
	logic [HANDLE_BITS-1:0] res_handle_q;
	logic [VC_FIELD_W-1:0]  res_vc_q;

	// output register
	logic                   out_valid_q;
	logic                   out_acc_q;
	logic                   out_pv_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	logic [VC_FIELD_W-1:0]  out_vc_q;
	logic [OCC_FIELD_W-1:0] out_occ_q;

	// ram signals
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [WORD_W-1:0] wr_word;
	logic [WORD_W-1:0] rd_word;

	// derived values for the current VC
	logic              in_acc;
	logic [PTR_W-1:0]  cur_head;
	logic [CNT_W-1:0]  cur_flits;
	logic [CNT_W-1:0]  cur_pkts;
	logic [PTR_W-1:0]  head_nx;
	logic [SUM_W-1:0]  pos_sum;
	logic [PTR_W-1:0]  wr_pos;
	logic [VC_W-1:0]   cur_vc_nx;
	logic              fits;
	logic              push_ok;
	logic              vc_hit;
	logic              scan_last;
	logic              drain_done;
	logic              out_free;
	logic              res_load;

	assign in_acc    = in_valid && in_ready;
	assign cur_head  = head_q[cur_vc_q];
	assign cur_flits = flit_cnt_q[cur_vc_q];
	assign cur_pkts  = pkt_cnt_q[cur_vc_q];

	// circular pointer arithmetic
	assign head_nx   = (cur_head == PTR_LAST) ? '0 : cur_head + PTR_W'(1);
	assign pos_sum   = SUM_W'(cur_head) + SUM_W'(cur_flits);
	assign wr_pos    = (pos_sum >= DEPTH_S) ? PTR_W'(pos_sum - DEPTH_S) : PTR_W'(pos_sum);
	assign cur_vc_nx = (cur_vc_q == VC_LAST) ? '0 : cur_vc_q + VC_W'(1);

	// push admission, capacity clipped to the fifo depth
	assign fits    = (32'(cur_flits) < 32'(cap_q)) && (cur_flits < DEPTH_C);
	assign push_ok = vc_ok_q && fits;

	// scan and drain conditions
	assign vc_hit     = (cur_pkts != '0) && (cur_flits != '0);
	assign scan_last  = (scan_cnt_q == VC_LAST);
	assign drain_done = rd_word[0] || (cur_flits == CNT_ONE);

	assign out_free = !out_valid_q || out_ready;

	// ram addressing: the region of the current VC plus a pointer
	assign wr_addr = ADDR_W'(cur_vc_q) * DEPTH_A + ADDR_W'(wr_pos);
	assign rd_addr = ADDR_W'(cur_vc_q) * DEPTH_A
		+ ADDR_W'((state_q == ST_DRAIN) ? head_nx : cur_head);
	assign wr_word = {handle_q, tail_q};

	vcpb_ram #(
		.WIDTH (WORD_W),
		.DEPTH (SLOTS)
	) u_flit_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (wr_addr),
		.wr_data (wr_word),
		.rd_en   (ram_re),
		.rd_addr (rd_addr),
		.rd_data (rd_word)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_nx = (action == ACT_POP) ? ST_SCAN : ST_PUSH;
				end
			end
			ST_PUSH: begin
				state_nx = ST_RESULT;
			end
			ST_SCAN: begin
				if (vc_hit) begin
					state_nx = ST_DRAIN;
				end else if (scan_last) begin
					state_nx = ST_RESULT;
				end
			end
			ST_DRAIN: begin
				if (drain_done) begin
					state_nx = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		res_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_PUSH: begin
				ram_we = push_ok;
			end
			ST_SCAN: begin
				ram_re = vc_hit;
			end
			ST_DRAIN: begin
				ram_re = !drain_done;
			end
			ST_RESULT: begin
				res_load = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// per-VC counters, turn and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VC_COUNT; i++) begin
				head_q[i]     <= '0;
				flit_cnt_q[i] <= '0;
				pkt_cnt_q[i]  <= '0;
			end
			rr_turn_q <= '0;
			total_q   <= '0;
		end else begin
			case (state_q)
				ST_PUSH: begin
					if (push_ok) begin
						flit_cnt_q[cur_vc_q] <= cur_flits + CNT_ONE;
						total_q              <= total_q + OCC_ONE;
						if (tail_q) begin
							pkt_cnt_q[cur_vc_q] <= cur_pkts + CNT_ONE;
						end
					end
				end
				ST_DRAIN: begin
					head_q[cur_vc_q]     <= head_nx;
					flit_cnt_q[cur_vc_q] <= cur_flits - CNT_ONE;
					total_q              <= total_q - OCC_ONE;
					if (drain_done) begin
						pkt_cnt_q[cur_vc_q] <= cur_pkts - CNT_ONE;
						rr_turn_q           <= cur_vc_nx;
					end
				end
				default: begin
					rr_turn_q <= rr_turn_q;
				end
			endcase
		end
	end

	// item capture and scan position
	always_ff @(posedge clk) begin
		if (in_acc) begin
			vc_ok_q    <= (32'(vc_index) < 32'(VC_COUNT));
			handle_q   <= flit_handle;
			tail_q     <= is_tail;
			cur_vc_q   <= (action == ACT_POP) ? rr_turn_q : VC_W'(vc_index);
			scan_cnt_q <= '0;
		end else if (state_q == ST_SCAN && !vc_hit && !scan_last) begin
			cur_vc_q   <= cur_vc_nx;
			scan_cnt_q <= scan_cnt_q + VC_W'(1);
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		case (state_q)
			ST_PUSH: begin
				res_acc_q    <= push_ok;
				res_pv_q     <= 1'b0;
				res_handle_q <= '0;
				res_vc_q     <= '0;
			end
			ST_SCAN: begin
				res_acc_q    <= 1'b0;
				res_pv_q     <= 1'b0;
				res_handle_q <= '0;
				res_vc_q     <= '0;
			end
			ST_DRAIN: begin
				res_handle_q <= rd_word[WORD_W-1:1];
				if (drain_done) begin
					res_pv_q <= 1'b1;
					res_vc_q <= VC_FIELD_W'(cur_vc_q);
				end
			end
			default: begin
				res_acc_q <= res_acc_q;
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_acc_q    <= res_acc_q;
			out_pv_q     <= res_pv_q;
			out_handle_q <= res_handle_q;
			out_vc_q     <= res_vc_q;
			out_occ_q    <= OCC_FIELD_W'(total_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign push_accepted   = out_acc_q;
	assign packet_valid    = out_pv_q;
	assign packet_handle   = out_handle_q;
	assign packet_vc       = out_vc_q;
	assign total_occupancy = out_occ_q;

endmodule : vc_packet_buffer_rr_arbiter_top

`default_nettype wire

@@ tb/sv/tb_vc_packet_buffer_rr_arbiter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vc_packet_buffer_rr_arbiter_top
// Self-checking bench for the per-VC packet buffer with round-robin pop.
// ----------------------------------------------------------------------------
// A queue of pending items feeds a clocked driver; a clocked monitor runs
// each accepted item through a local model of the VC FIFOs, packet counts
// and round-robin turn, and compares every result against the oldest
// prediction. Directed items cover empty pops, multi-flit packets, skipped
// VCs, full VCs and capacity clipping; random phases follow, each with its
// own capacity and a mix of whole packets, pops and stray flits. Both sides
// idle at random, and the receiver holds off for long stretches twice.
// ----------------------------------------------------------------------------

module tb_vc_packet_buffer_rr_arbiter_top;
	import vcpb_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT   = 3000;

	typedef struct packed {
		logic                       act;
		logic [VC_FIELD_W-1:0]      vc;
		logic [HANDLE_BITS_DEF-1:0] handle;
		logic                       tail;
	} flit_item_t;

	typedef struct packed {
		logic                       accepted;
		logic                       pkt_valid;
		logic [HANDLE_BITS_DEF-1:0] handle;
		logic [VC_FIELD_W-1:0]      vc;
		logic [OCC_FIELD_W-1:0]     occ;
	} buffer_result_t;

	// block ports
	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CAP_W-1:0]           cfg_wdata = CAP_RESET;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic                       action = ACT_PUSH;
	logic [VC_FIELD_W-1:0]      vc_index = '0;
	logic [HANDLE_BITS_DEF-1:0] flit_handle = '0;
	logic                       is_tail = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic                       push_accepted;
	logic                       packet_valid;
	logic [HANDLE_BITS_DEF-1:0] packet_handle;
	logic [VC_FIELD_W-1:0]      packet_vc;
	logic [OCC_FIELD_W-1:0]     total_occupancy;

	// handshake bookkeeping
	flit_item_t     pending_items[$];
	buffer_result_t due_results[$];
	int             queued_total = 0;
	int             results_seen = 0;
	int             error_count = 0;
	logic           in_took = 1'b0;
	logic           out_took = 1'b0;

	// idling state of each side
	int send_wait = 0, send_mode = 0, send_left = 0;
	int recv_wait = 0, recv_mode = 0, recv_left = 0;
	int hold_requests = 0, holds_served = 0, hold_left = 0;

	// local copy of the buffer state
	logic [HANDLE_BITS_DEF-1:0] lane_handle [VC_COUNT_DEF][VC_DEPTH_DEF];
	logic                       lane_tail   [VC_COUNT_DEF][VC_DEPTH_DEF];
	int unsigned                lane_head   [VC_COUNT_DEF] = '{default: 0};
	int unsigned                lane_flits  [VC_COUNT_DEF] = '{default: 0};
	int unsigned                lane_pkts   [VC_COUNT_DEF] = '{default: 0};
	int unsigned                rr_next = 0;
	int unsigned                cap_reg = CAP_RESET;

	vc_packet_buffer_rr_arbiter_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.vc_index        (vc_index),
		.flit_handle     (flit_handle),
		.is_tail         (is_tail),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.push_accepted   (push_accepted),
		.packet_valid    (packet_valid),
		.packet_handle   (packet_handle),
		.packet_vc       (packet_vc),
		.total_occupancy (total_occupancy)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// apply one item to the local buffer state and return its result
	function automatic buffer_result_t advance_buffer(input flit_item_t it);
		buffer_result_t r;
		int unsigned    lim, v, slot, sum;
		logic           at_end;
		r = '0;
		lim = (cap_reg > VC_DEPTH_DEF) ? VC_DEPTH_DEF : cap_reg;
		if (it.act == ACT_PUSH) begin
			v = it.vc;
			if (v < VC_COUNT_DEF && lane_flits[v] < lim) begin
				slot = (lane_head[v] + lane_flits[v]) % VC_DEPTH_DEF;
				lane_handle[v][slot] = it.handle;
				lane_tail[v][slot] = it.tail;
				lane_flits[v]++;
				if (it.tail)
					lane_pkts[v]++;
				r.accepted = 1'b1;
			end
		end else begin
			// first VC from the turn holding a whole packet
			for (int k = 0; k < VC_COUNT_DEF && !r.pkt_valid; k++) begin
				v = (rr_next + k) % VC_COUNT_DEF;
				if (lane_pkts[v] > 0 && lane_flits[v] > 0) begin
					at_end = 1'b0;
					while (lane_flits[v] > 0 && !at_end) begin
						r.handle = lane_handle[v][lane_head[v]];
						at_end = lane_tail[v][lane_head[v]];
						lane_head[v] = (lane_head[v] + 1) % VC_DEPTH_DEF;
						lane_flits[v]--;
					end
					lane_pkts[v]--;
					r.pkt_valid = 1'b1;
					r.vc = VC_FIELD_W'(v);
					rr_next = (v + 1) % VC_COUNT_DEF;
				end
			end
		end
		sum = 0;
		for (int k = 0; k < VC_COUNT_DEF; k++)
			sum += lane_flits[k];
		r.occ = OCC_FIELD_W'(sum);
		return r;
	endfunction

	// idle cycles before the next item, in stretches of calm, light or busy
	function automatic int draw_gap(inout int mode, inout int left);
		if (left == 0) begin
			mode = $urandom_range(0, 2);
			left = $urandom_range(10, 60);
		end
		left--;
		case (mode)
			0: return 0;
			1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
			default: return $urandom_range(0, 13);
		endcase
	endfunction

	// sender: one item per handshake, payload held until taken
	always @(negedge clk) begin : tx_side
		flit_item_t nxt;
		if (arst_n && !(in_valid && !in_took)) begin
			if (send_wait > 0) begin
				in_valid <= 1'b0;
				send_wait <= send_wait - 1;
			end else if (pending_items.size() != 0) begin
				nxt = pending_items.pop_front();
				in_valid <= 1'b1;
				action <= nxt.act;
				vc_index <= nxt.vc;
				flit_handle <= nxt.handle;
				is_tail <= nxt.tail;
				send_wait <= draw_gap(send_mode, send_left);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus long hold-offs on request
	always @(negedge clk) begin : rx_side
		int w;
		if (arst_n) begin
			if (hold_requests != holds_served) begin
				holds_served <= holds_served + 1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= (hold_left == 1);
			end else if (out_took) begin
				w = draw_gap(recv_mode, recv_left);
				recv_wait <= w;
				out_ready <= (w == 0);
			end else if (recv_wait > 0) begin
				recv_wait <= recv_wait - 1;
				out_ready <= (recv_wait == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor: predict on input handshake, check on output handshake
	always @(posedge clk) begin : watch_side
		buffer_result_t got, want;
		if (arst_n) begin
			in_took <= in_valid && in_ready;
			out_took <= out_valid && out_ready;
			if (out_valid && out_ready) begin
				results_seen++;
				got = '{push_accepted, packet_valid, packet_handle, packet_vc,
					total_occupancy};
				if (due_results.size() == 0) begin
					$error("result with nothing expected: %h", got);
					error_count++;
				end else begin
					want = due_results.pop_front();
					if (got.accepted !== want.accepted) begin
						$error("push_accepted: expected %0d, got %0d", want.accepted,
							got.accepted);
						error_count++;
					end
					if (got.pkt_valid !== want.pkt_valid) begin
						$error("packet_valid: expected %0d, got %0d", want.pkt_valid,
							got.pkt_valid);
						error_count++;
					end
					if (got.handle !== want.handle) begin
						$error("packet_handle: expected %h, got %h", want.handle,
							got.handle);
						error_count++;
					end
					if (got.vc !== want.vc) begin
						$error("packet_vc: expected %0d, got %0d", want.vc, got.vc);
						error_count++;
					end
					if (got.occ !== want.occ) begin
						$error("total_occupancy: expected %0d, got %0d", want.occ,
							got.occ);
						error_count++;
					end
				end
			end
			if (in_valid && in_ready)
				due_results.insert(due_results.size(), advance_buffer('{action,
					vc_index, flit_handle, is_tail}));
		end
	end

	// watchdog on cycles with no handshake at all
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

	task automatic queue_item(input logic act, input logic [VC_FIELD_W-1:0] vc,
		input logic [HANDLE_BITS_DEF-1:0] h, input logic t);
		flit_item_t fresh;
		fresh = '{act, vc, h, t};
		pending_items.insert(pending_items.size(), fresh);
		queued_total++;
	endtask

	// whole packets on random VCs, pops, and the odd stray flit
	task automatic queue_traffic(input int count, input int pop_pct);
		int                    made, len, pick;
		logic [VC_FIELD_W-1:0] lane;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(0, 99);
			if (pick < pop_pct) begin
				queue_item(ACT_POP, VC_FIELD_W'($urandom), HANDLE_BITS_DEF'($urandom),
					1'($urandom));
				made++;
			end else if (pick < pop_pct + 6) begin
				queue_item(ACT_PUSH, VC_FIELD_W'($urandom), HANDLE_BITS_DEF'($urandom),
					1'($urandom));
				made++;
			end else begin
				lane = VC_FIELD_W'($urandom);
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 17)
					: $urandom_range(1, 4);
				for (int i = 1; i <= len; i++)
					queue_item(ACT_PUSH, lane, HANDLE_BITS_DEF'($urandom), i == len);
				made += len;
			end
		end
	endtask

	// every result in, then a margin for the longest pop
	task automatic wait_drained();
		while (results_seen < queued_total)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] value);
		wait_drained();
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		cap_reg = value;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset capacity: empty pop, multi-flit packet, skip of an open packet
		queue_item(ACT_POP, '0, '0, 1'b0);
		queue_item(ACT_PUSH, 2'd0, 16'h0000, 1'b0);
		queue_item(ACT_PUSH, 2'd0, 16'hFFFF, 1'b1);
		queue_item(ACT_PUSH, 2'd3, 16'hAAAA, 1'b1);
		queue_item(ACT_PUSH, 2'd1, 16'h5555, 1'b1);
		queue_item(ACT_PUSH, 2'd2, 16'h8001, 1'b0);
		queue_item(ACT_POP, '0, '0, 1'b0);
		queue_item(ACT_POP, '0, '0, 1'b0);
		queue_item(ACT_POP, '0, '0, 1'b0);
		queue_item(ACT_POP, 2'd3, 16'hFFFF, 1'b1);

		// capacity of one: full VCs refuse
		set_capacity(5'd1);
		queue_item(ACT_PUSH, 2'd2, 16'h1234, 1'b1);
		queue_item(ACT_PUSH, 2'd0, 16'h00FF, 1'b1);
		queue_item(ACT_PUSH, 2'd0, 16'hFF00, 1'b1);

		// capacity zero: nothing stored, pops still drain
		set_capacity(5'd0);
		queue_item(ACT_PUSH, 2'd3, 16'h7FFE, 1'b1);
		queue_item(ACT_POP, '0, '0, 1'b0);

		// capacity above the depth is clipped
		set_capacity(5'd31);
		queue_item(ACT_PUSH, 2'd2, 16'hC3C3, 1'b1);
		queue_item(ACT_POP, '0, '0, 1'b0);
		queue_item(ACT_POP, '0, '0, 1'b0);

		// random phases, with the receiver holding off to fill the buffer
		set_capacity(5'd16);
		hold_requests++;
		queue_traffic(120, 20);
		set_capacity(5'd2);
		queue_traffic(100, 35);
		set_capacity(5'd1);
		queue_traffic(80, 40);
		set_capacity(5'd0);
		queue_traffic(60, 50);
		set_capacity(5'd31);
		hold_requests++;
		queue_traffic(120, 25);
		set_capacity(5'd17);
		queue_traffic(80, 40);
		set_capacity(CAP_W'($urandom_range(3, 15)));
		queue_traffic(100, 35);
		set_capacity(CAP_W'($urandom_range(3, 15)));
		queue_traffic(100, 35);
		set_capacity(5'd16);
		queue_traffic(100, 60);

		wait_drained();
		if (due_results.size() != 0) begin
			$error("%0d results never arrived", due_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ vc_packet_buffer_rr_arbiter_top.f @@
design/vcpb_pkg.sv
design/vcpb_ram.sv
design/vc_packet_buffer_rr_arbiter_top.sv
tb/sv/tb_vc_packet_buffer_rr_arbiter_top.sv
